>>> sv/dmwbc_pkg.sv
`timescale 1ns / 1ps
package dmwbc_pkg;
  localparam int unsigned NumSetsDef    = 64;
  localparam int unsigned BlockBytesDef = 64;
  localparam int unsigned WordW         = 32;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RESP_DONE = 2'd0,
    RESP_WB   = 2'd1,
    RESP_FREQ = 2'd2
  } resp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FREQ,
    ST_WAIT,
    ST_FINAL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic meta_rd;
    logic hit_upd;
    logic wb_rd;
    logic wb_emit;
    logic freq_emit;
    logic fill_wr;
    logic final_wr;
    logic final_rd;
    logic finish_emit;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic hit;
    logic victim_dirty;
    logic wb_last;
    logic fill_last;
  } sts_t;
endpackage

>>> sv/dmwbc_ram.sv
`timescale 1ns / 1ps
module dmwbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> sv/dmwbc_ctrl.sv
`timescale 1ns / 1ps
module dmwbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        kind_i,
  input  dmwbc_pkg::sts_t   sts_i,
  output dmwbc_pkg::cmd_t   cmd_o,
  output logic              busy_o
);
  import dmwbc_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   acc, is_acc, is_fill;

  assign acc     = start_i && !busy_o;
  assign is_acc  = (kind_i == KIND_READ) || (kind_i == KIND_WRITE);
  assign is_fill = (kind_i == KIND_FILL);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && is_acc && !pend_q) state_d = ST_LOOKUP;
        if (acc && is_fill && pend_q) begin
          state_d = sts_i.fill_last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.hit) state_d = ST_IDLE;
        else if (sts_i.victim_dirty) state_d = ST_WB;
        else state_d = ST_FREQ;
      end
      ST_WB:     if (sts_i.wb_last) state_d = ST_FREQ;
      ST_FREQ: begin
        state_d = ST_IDLE;
        pend_d  = 1'b1;
      end
      ST_FINAL:  state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_FINISH;
      ST_FINISH: begin
        state_d = ST_IDLE;
        pend_d  = 1'b0;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch   = acc && is_acc && !pend_q;
        cmd_o.meta_rd = acc && is_acc && !pend_q;
        cmd_o.fill_wr = acc && is_fill && pend_q;
      end
      ST_LOOKUP: begin
        cmd_o.hit_upd = sts_i.hit;
        cmd_o.wb_rd   = !sts_i.hit && sts_i.victim_dirty;
      end
      ST_WB: begin
        cmd_o.wb_emit = 1'b1;
        cmd_o.wb_rd   = !sts_i.wb_last;
      end
      ST_FREQ:   cmd_o.freq_emit = 1'b1;
      ST_FINAL:  cmd_o.final_wr = 1'b1;
      ST_WAIT:   cmd_o.final_rd = 1'b1;
      ST_FINISH: cmd_o.finish_emit = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  a_lookup_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> $past(state_q) == ST_IDLE) else $error("lookup entry");
  a_no_acc_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |-> !pend_q) else $error("access while pending");
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> !pend_q) else $error("pending kept");
endmodule

>>> sv/dmwbc_dp.sv
`timescale 1ns / 1ps
module dmwbc_dp #(
  parameter int unsigned NumSets    = dmwbc_pkg::NumSetsDef,
  parameter int unsigned BlockBytes = dmwbc_pkg::BlockBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_data_i,
  input  logic [1:0]      kind_i,
  input  logic [31:0]     access_addr_i,
  input  logic [31:0]     store_value_i,
  input  logic [31:0]     fill_word_i,
  input  dmwbc_pkg::cmd_t cmd_i,
  output dmwbc_pkg::sts_t sts_o,
  output logic            resp_valid_o,
  output logic [1:0]      resp_kind_o,
  output logic [31:0]     resp_addr_o,
  output logic [31:0]     resp_data_o,
  output logic            was_hit_o,
  output logic            last_o
);
  import dmwbc_pkg::*;

  localparam int unsigned LineWords = BlockBytes / 4;
  localparam int unsigned OffW  = $clog2(BlockBytes);
  localparam int unsigned WordIdxW = (LineWords > 1) ? $clog2(LineWords) : 1;
  localparam int unsigned SetW  = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned SetB  = $clog2(NumSets);
  localparam int unsigned TagW  = 32 - OffW - SetB;
  localparam int unsigned Depth = NumSets * LineWords;
  localparam int unsigned AddrW = $clog2(Depth) > 0 ? $clog2(Depth) : 1;

  logic [31:0] base_q;
  logic [31:0] paddr_q;
  logic [31:0] pval_q;
  logic        pwr_q;
  logic [WordIdxW:0] cnt_q;
  logic [NumSets-1:0] valid_q, dirty_q;

  logic [31:0]   off32, lstart, nblk;
  logic [SetW-1:0] set_s;
  logic [TagW-1:0] tag_s;
  logic [WordIdxW-1:0] word_s;

  // address split of the pending address with current base
  always_comb begin
    off32  = (paddr_q - base_q) & 32'(BlockBytes - 1);
    lstart = paddr_q - off32;
    nblk   = lstart >> OffW;
    if (NumSets > 1) set_s = nblk[SetW-1:0];
    else set_s = '0;
    tag_s  = nblk[SetB +: TagW];
    if (LineWords > 1) word_s = WordIdxW'(off32 >> 2);
    else word_s = '0;
  end

  // set of the incoming word, for the tag read at accept
  logic [31:0]     in_off, in_lstart;
  logic [SetW-1:0] set_in;
  always_comb begin
    in_off    = (access_addr_i - base_q) & 32'(BlockBytes - 1);
    in_lstart = access_addr_i - in_off;
    if (NumSets > 1) set_in = in_lstart[OffW +: SetW];
    else set_in = '0;
  end

  logic [TagW-1:0] tag_rd;
  logic [31:0]     wd_rd;
  logic            tag_we;
  logic            wd_we;
  logic [AddrW-1:0] wd_waddr, wd_raddr;
  logic [31:0]     wd_wdata;
  logic [SetW-1:0] tag_raddr;

  logic [AddrW-1:0] line_base;
  assign line_base = (NumSets > 1) ? AddrW'(set_s) * AddrW'(LineWords) : '0;

  logic [WordIdxW:0] wb_idx_q;
  logic tag_eq, vld;
  assign vld    = valid_q[set_s];
  assign tag_eq = (tag_rd == tag_s);

  assign sts_o.is_write     = pwr_q;
  assign sts_o.hit          = vld && tag_eq;
  assign sts_o.victim_dirty = vld && dirty_q[set_s];
  assign sts_o.wb_last      = (wb_idx_q == (WordIdxW+1)'(LineWords));
  assign sts_o.fill_last    = (cnt_q == (WordIdxW+1)'(LineWords - 1));

  // tag read at accept lands in lookup; later it follows the pending set
  always_comb begin
    tag_raddr = cmd_i.meta_rd ? set_in : set_s;
    tag_we    = cmd_i.final_wr;
  end

  dmwbc_ram #(.Width(TagW), .Depth(NumSets)) u_tags (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(set_s),
    .wdata_i(tag_s),
    .raddr_i(tag_raddr),
    .rdata_o(tag_rd)
  );

  always_comb begin
    wd_we    = 1'b0;
    wd_waddr = line_base + AddrW'(word_s);
    wd_wdata = pval_q;
    wd_raddr = line_base + AddrW'(word_s);
    if (cmd_i.hit_upd && pwr_q) wd_we = 1'b1;
    if (cmd_i.fill_wr) begin
      wd_we    = 1'b1;
      wd_waddr = line_base + AddrW'(cnt_q[WordIdxW-1:0]);
      wd_wdata = fill_word_i;
    end
    if (cmd_i.final_wr && pwr_q) wd_we = 1'b1;
    if (cmd_i.final_rd) wd_raddr = line_base + AddrW'(word_s);
    if (cmd_i.wb_rd) wd_raddr = line_base + AddrW'(wb_idx_q[WordIdxW-1:0]);
  end

  dmwbc_ram #(.Width(32), .Depth(Depth)) u_words (
    .clk_i  (clk_i),
    .we_i   (wd_we),
    .waddr_i(wd_waddr),
    .wdata_i(wd_wdata),
    .raddr_i(wd_raddr),
    .rdata_o(wd_rd)
  );

  logic [31:0] vstart;
  assign vstart = ((32'(tag_rd) << SetB) | 32'(set_s)) * 32'(BlockBytes)
                  + (base_q & 32'(BlockBytes - 1));
  logic [31:0] wb_addr_q;

  // hit read data comes from a registered read: delay the read-hit response via hit_rd_q
  logic hit_rd_q;

  logic [1:0]  rk_d;
  logic [31:0] ra_d, rd_d;
  logic        rv_d, rh_d, rl_d;

  always_comb begin
    rv_d = 1'b0; rk_d = RESP_DONE; ra_d = paddr_q; rd_d = '0; rh_d = 1'b0; rl_d = 1'b0;
    if (cmd_i.hit_upd) begin
      rv_d = pwr_q; rh_d = 1'b1; rl_d = 1'b1;
      rd_d = 32'(0);
    end
    if (cmd_i.wb_emit) begin
      rv_d = 1'b1; rk_d = RESP_WB; ra_d = wb_addr_q; rd_d = wd_rd;
    end
    if (cmd_i.freq_emit) begin
      rv_d = 1'b1; rk_d = RESP_FREQ; ra_d = lstart; rl_d = 1'b1;
    end
    if (cmd_i.finish_emit) begin
      rv_d = 1'b1; rl_d = 1'b1; rd_d = pwr_q ? '0 : wd_rd;
    end
    if (hit_rd_q) begin
      rv_d = 1'b1; rk_d = RESP_DONE; ra_d = paddr_q; rd_d = wd_rd; rh_d = 1'b1; rl_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      paddr_q  <= '0;
      pval_q   <= '0;
      pwr_q    <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= '0;
      dirty_q  <= '0;
      wb_idx_q <= '0;
      wb_addr_q <= '0;
      resp_valid_o <= 1'b0;
      resp_kind_o  <= '0;
      resp_addr_o  <= '0;
      resp_data_o  <= '0;
      was_hit_o    <= 1'b0;
      last_o       <= 1'b0;
      hit_rd_q     <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_data_i;
      if (cmd_i.latch) begin
        paddr_q <= access_addr_i;
        pval_q  <= store_value_i;
        pwr_q   <= (kind_i == KIND_WRITE);
        cnt_q   <= '0;
        wb_idx_q <= '0;
      end
      if (cmd_i.hit_upd && pwr_q) dirty_q[set_s] <= 1'b1;
      if (cmd_i.wb_rd) wb_idx_q <= wb_idx_q + 1'b1;
      if (cmd_i.wb_rd) wb_addr_q <= vstart + 32'({wb_idx_q, 2'b00});
      if (cmd_i.freq_emit) begin
        valid_q[set_s] <= 1'b0;
        dirty_q[set_s] <= 1'b0;
      end
      if (cmd_i.fill_wr) cnt_q <= sts_o.fill_last ? '0 : cnt_q + 1'b1;
      if (cmd_i.final_wr) begin
        valid_q[set_s] <= 1'b1;
        dirty_q[set_s] <= pwr_q;
      end
      hit_rd_q <= cmd_i.hit_upd && !pwr_q;
      resp_valid_o <= rv_d;
      resp_kind_o  <= rk_d;
      resp_addr_o  <= ra_d;
      resp_data_o  <= rd_d;
      was_hit_o    <= rh_d;
      last_o       <= rl_d;
    end
  end

  a_one_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wb_emit && cmd_i.freq_emit)) else $error("two responses");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < (WordIdxW+1)'(LineWords)) else $error("fill count overflow");
  a_valid_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.final_wr |=> valid_q[$past(set_s)]) else $error("line not valid");
endmodule

>>> sv/direct_mapped_writeback_cache.sv
`timescale 1ns / 1ps
// Hit: 1 word accepted, busy in the lookup state; read hits pass through hit_rd_q.
// Miss: busy through lookup, dirty victim write-back (if any) and fill request,
// then fill words accepted one a cycle; the last keeps it busy in final/wait/finish.
// Results cannot be stalled by the receiver. Reset clears valid/dirty bits,
// the base register and the controller; tag and data arrays are not cleared.
module direct_mapped_writeback_cache #(
  parameter int unsigned NumSets    = dmwbc_pkg::NumSetsDef,
  parameter int unsigned BlockBytes = dmwbc_pkg::BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] access_addr_i,
  input  logic [31:0] store_value_i,
  input  logic [31:0] fill_word_i,
  output logic        resp_valid_o,
  output logic [1:0]  resp_kind_o,
  output logic [31:0] resp_addr_o,
  output logic [31:0] resp_data_o,
  output logic        was_hit_o,
  output logic        last_o
);
  import dmwbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dmwbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  dmwbc_dp #(.NumSets(NumSets), .BlockBytes(BlockBytes)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .access_addr_i(access_addr_i),
    .store_value_i(store_value_i),
    .fill_word_i  (fill_word_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .resp_valid_o (resp_valid_o),
    .resp_kind_o  (resp_kind_o),
    .resp_addr_o  (resp_addr_o),
    .resp_data_o  (resp_data_o),
    .was_hit_o    (was_hit_o),
    .last_o       (last_o)
  );
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dmwbc_pkg::*;

  localparam int unsigned Sets      = NumSetsDef;
  localparam int unsigned LineBytes = BlockBytesDef;
  localparam int unsigned LineWords = LineBytes / 4;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainWait = 30;

  typedef struct {
    resp_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        hit;
    logic        last;
  } resp_t;

  class cache_scoreboard;
    logic [31:0] base;
    logic [19:0] tags [Sets];
    bit          valid [Sets];
    bit          dirty [Sets];
    logic [31:0] words [Sets*LineWords];
    bit          miss_open;
    bit          miss_is_write;
    logic [31:0] miss_addr;
    logic [31:0] miss_value;
    int          fills;
    resp_t       resp_q[$];
    int          errors;

    function new();
      base = '0;
      for (int i = 0; i < Sets; i++) begin
        valid[i] = 0;
        dirty[i] = 0;
      end
      miss_open = 0;
      errors = 0;
    endfunction

    function void split(input logic [31:0] addr, output int set, output logic [19:0] tag,
                        output int word, output logic [31:0] line_start);
      logic [31:0] off;
      logic [31:0] n;
      off = (addr - base) % LineBytes;
      line_start = addr - off;
      n = line_start / LineBytes;
      set = n % Sets;
      tag = 20'(n / Sets);
      word = off / 4;
      if (word >= LineWords) word = LineWords - 1;
    endfunction

    function void push(resp_e k, logic [31:0] a, logic [31:0] d, logic h, logic l);
      resp_t r;
      r.kind = k;
      r.addr = a;
      r.data = d;
      r.hit = h;
      r.last = l;
      resp_q.push_back(r);
    endfunction

    function void note(kind_e k, logic [31:0] addr, logic [31:0] sval, logic [31:0] fword);
      int          set;
      int          word;
      logic [19:0] tag;
      logic [31:0] ls;
      logic [31:0] vstart;
      logic [31:0] d;
      if (k == KIND_READ || k == KIND_WRITE) begin
        if (miss_open) return;
        split(addr, set, tag, word, ls);
        if (valid[set] && tags[set] == tag) begin
          d = '0;
          if (k == KIND_WRITE) begin
            words[set*LineWords + word] = sval;
            dirty[set] = 1;
          end else begin
            d = words[set*LineWords + word];
          end
          push(RESP_DONE, addr, d, 1'b1, 1'b1);
          return;
        end
        if (valid[set] && dirty[set]) begin
          vstart = (32'(tags[set]) * Sets + set) * LineBytes + base % LineBytes;
          for (int i = 0; i < LineWords; i++)
            push(RESP_WB, vstart + 4*i, words[set*LineWords + i], 1'b0, 1'b0);
        end
        valid[set] = 0;
        dirty[set] = 0;
        miss_open = 1;
        miss_is_write = (k == KIND_WRITE);
        miss_addr = addr;
        miss_value = sval;
        fills = 0;
        push(RESP_FREQ, ls, '0, 1'b0, 1'b1);
      end else if (k == KIND_FILL) begin
        if (!miss_open) return;
        split(miss_addr, set, tag, word, ls);
        words[set*LineWords + fills] = fword;
        fills++;
        if (fills < LineWords) return;
        tags[set] = tag;
        valid[set] = 1;
        d = '0;
        if (miss_is_write) begin
          words[set*LineWords + word] = miss_value;
          dirty[set] = 1;
        end else begin
          dirty[set] = 0;
          d = words[set*LineWords + word];
        end
        miss_open = 0;
        fills = 0;
        push(RESP_DONE, miss_addr, d, 1'b0, 1'b1);
      end
    endfunction

    function void check(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic h, logic l);
      resp_t e;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected word kind=%0d addr=%h data=%h", $time, k, a, d);
        errors++;
        return;
      end
      e = resp_q.pop_front();
      if (k !== e.kind || a !== e.addr || d !== e.data || h !== e.hit || l !== e.last) begin
        $display("%0t: exp kind=%0d addr=%h data=%h hit=%0d last=%0d", $time,
                 e.kind, e.addr, e.data, e.hit, e.last);
        $display("%0t: got kind=%0d addr=%h data=%h hit=%0d last=%0d", $time,
                 k, a, d, h, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic [1:0]  kind_i = '0;
  logic [31:0] access_addr_i = '0;
  logic [31:0] store_value_i = '0;
  logic [31:0] fill_word_i = '0;
  logic        resp_valid_o;
  logic [1:0]  resp_kind_o;
  logic [31:0] resp_addr_o;
  logic [31:0] resp_data_o;
  logic        was_hit_o;
  logic        last_o;

  cache_scoreboard sb = new();
  int idle_cyc = 0;
  int sent = 0;

  direct_mapped_writeback_cache dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && resp_valid_o)
      sb.check(resp_kind_o, resp_addr_o, resp_data_o, was_hit_o, last_o);
    if (rst_ni && (resp_valid_o || (start_i && !busy_o))) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send(kind_e k, logic [31:0] a, logic [31:0] s, logic [31:0] f, int gap);
    @(negedge clk_i);
    start_i <= 1'b1;
    kind_i <= k;
    access_addr_i <= a;
    store_value_i <= s;
    fill_word_i <= f;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note(k, a, s, f);
    if (k != KIND_NONE) sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.resp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_base(logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    sb.base = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // access, then stream the line in if it missed; noise optional
  task automatic access(kind_e k, logic [31:0] a, logic [31:0] s, bit noisy);
    send(k, a, s, $urandom(), pick_gap());
    while (sb.miss_open) begin
      if (noisy && $urandom_range(9) == 0)
        send(kind_e'($urandom_range(1) ? KIND_NONE : KIND_READ), $urandom(), $urandom(),
             $urandom(), pick_gap());
      else
        send(KIND_FILL, $urandom(), $urandom(), $urandom(), pick_gap());
    end
  endtask

  function automatic logic [31:0] pool_addr();
    logic [19:0] t;
    case ($urandom_range(3))
      0: t = 20'h0;
      1: t = 20'h1;
      2: t = 20'h2;
      default: t = 20'hFFFFF;
    endcase
    if ($urandom_range(9) == 0) return $urandom();
    return sb.base + (32'(t) * Sets + $urandom_range(7)) * LineBytes
           + $urandom_range(LineWords - 1) * 4 + $urandom_range(3);
  endfunction

  initial begin
    logic [31:0] b;
    bit          moved_a;
    bit          moved_b;
    moved_a = 1'b0;
    moved_b = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(KIND_FILL, '0, '0, 32'hFFFFFFFF, 1);
    send(KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    access(KIND_READ, 32'h0, 32'h0, 0);
    access(KIND_READ, 32'h4, 32'h0, 0);
    access(KIND_WRITE, 32'h3C, 32'hFFFFFFFF, 0);
    access(KIND_WRITE, 32'h1000, 32'h5A5A5A5A, 1);
    access(KIND_READ, 32'h3F, 32'h0, 0);
    access(KIND_WRITE, 32'hFFFFFFFF, 32'h0, 1);
    access(KIND_READ, 32'hFFFFFFFC, 32'h0, 0);
    access(KIND_READ, 32'h0FFFFFC0, 32'h0, 0);

    set_base(32'hFFFFFFFF);
    access(KIND_WRITE, 32'h0, 32'h12345678, 0);
    access(KIND_READ, 32'h3, 32'h0, 0);
    set_base(32'hFFFFFFC0);
    access(KIND_READ, 32'h7FFFFFC0, 32'h0, 0);

    while (sent < 210) begin
      if (!moved_a && sent > 80) begin
        case ($urandom_range(3))
          0: b = $urandom() & 32'hFFFFFFC0;
          1: b = $urandom();
          2: b = 32'h0;
          default: b = 32'hFFFFFFFF;
        endcase
        set_base(b);
        moved_a = 1'b1;
      end else if (!moved_b && sent > 150) begin
        set_base($urandom() & 32'hFFFFFFC0);
        moved_b = 1'b1;
      end
      if ($urandom_range(19) == 0)
        send(KIND_FILL, $urandom(), $urandom(), $urandom(), pick_gap());
      else if ($urandom_range(29) == 0)
        send(KIND_NONE, $urandom(), $urandom(), $urandom(), pick_gap());
      else
        access(kind_e'($urandom_range(1)), pool_addr(), $urandom(), 1);
    end

    drain();
    if (sb.errors == 0 && sb.resp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/dmwbc_pkg.sv
sv/dmwbc_ram.sv
sv/dmwbc_ctrl.sv
sv/dmwbc_dp.sv
sv/direct_mapped_writeback_cache.sv
tb/sv/tb_top.sv
